// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hw/rtl/bcsr_pkg.sv
// Package: types, constants and command/status structs of the block-CSR matvec block.
package bcsr_pkg;
	localparam int BlockSize    = 4;
	localparam int MaxBlockRows = 512;
	localparam int MaxBlocks    = 2048;
	localparam int PtrDepth     = MaxBlockRows + 1;
	localparam int ElemDepth    = MaxBlocks * BlockSize * BlockSize;
	localparam int VecDepth     = MaxBlockRows * BlockSize;
	localparam int PtrAw  = $clog2(PtrDepth);
	localparam int ColAw  = $clog2(MaxBlocks);
	localparam int ElemAw = $clog2(ElemDepth);
	localparam int VecAw  = $clog2(VecDepth);
	localparam int BsW    = $clog2(BlockSize + 1);
	localparam int RowW   = $clog2(MaxBlockRows + 1);
	localparam int AccW   = 72;

	localparam logic [2:0] MODE_PTR = 3'd0, MODE_COL = 3'd1, MODE_ELEM = 3'd2,
		MODE_VEC = 3'd3, MODE_RES = 3'd4, MODE_COMPUTE = 3'd5, MODE_READ = 3'd6;
	localparam logic [1:0] ST_OK = 2'd0, ST_DONE = 2'd1, ST_RANGE = 2'd2, ST_SAT = 2'd3;
	localparam logic [0:0] CFG_ROWS = 1'b0, CFG_TRANS = 1'b1;

	typedef struct packed {
		logic [2:0]         mode;
		logic [14:0]        address;
		logic signed [31:0] data_value;
		logic [11:0]        pointer_value;
		logic [8:0]         column_value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [1:0]         status;
	} out_item_t;

	// Datapath operations issued by the controller each cycle.
	localparam logic [3:0] OP_NONE = 4'd0, OP_LOAD = 4'd1, OP_PTR_RD = 4'd2,
		OP_COL_RD = 4'd3, OP_MAC = 4'd4, OP_WB = 4'd5, OP_RES_RD = 4'd6;

	typedef struct packed {
		logic [3:0]         op;
		logic [2:0]         mode;
		logic [14:0]        address;
		logic signed [31:0] data_value;
		logic [11:0]        pointer_value;
		logic [8:0]         column_value;
		logic [PtrAw-1:0]   ptr_addr;
		logic [ColAw-1:0]   col_addr;
		logic [ElemAw-1:0]  elem_addr;
		logic [VecAw-1:0]   vec_addr;
		logic [VecAw-1:0]   res_addr;
		logic               acc_clear;
		logic               commit;
	} dp_cmd_t;

	typedef struct packed {
		logic [11:0]        ptr_data;
		logic [8:0]         col_data;
		logic               res_sat;
	} dp_stat_t;
endpackage

// File: hw/rtl/bcsr_datapath.sv
// Datapath: the five stores, the multiply-accumulate and the saturating r update.
module bcsr_datapath import bcsr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  dp_cmd_t   cmd,
	output dp_stat_t  stat,
	output logic signed [31:0] res_rd
);
	logic [11:0]        ptr_mem  [PtrDepth];
	logic [8:0]         col_mem  [MaxBlocks];
	logic signed [31:0] elem_mem [ElemDepth];
	logic signed [31:0] vec_mem  [VecDepth];
	logic signed [31:0] res_mem  [VecDepth];

	logic [11:0]        ptr_q;
	logic [8:0]         col_q;
	logic signed [31:0] elem_s1, vec_s1, res_q;
	logic               mac_s1, mac_s2;
	logic signed [63:0] prod_s2;
	logic signed [AccW-1:0] acc_q;
	logic               sat_q;
	logic [VecAw-1:0]   wb_addr_q;
	logic               wb_q;

	// Loads and registered reads.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			unique case (cmd.mode)
				MODE_PTR:  ptr_mem[cmd.address[PtrAw-1:0]] <= cmd.pointer_value;
				MODE_COL:  col_mem[cmd.address[ColAw-1:0]] <= cmd.column_value;
				MODE_ELEM: elem_mem[cmd.address[ElemAw-1:0]] <= cmd.data_value;
				MODE_VEC:  vec_mem[cmd.address[VecAw-1:0]] <= cmd.data_value;
				default:   ;
			endcase
		end
		ptr_q   <= ptr_mem[cmd.ptr_addr];
		col_q   <= col_mem[cmd.col_addr];
		elem_s1 <= elem_mem[cmd.elem_addr];
		vec_s1  <= vec_mem[cmd.vec_addr];
	end

	// r store: one write port shared by load and writeback.
	logic signed [AccW-1:0] rnd;
	logic signed [AccW-1:0] sum;
	logic signed [31:0]     sat_val;
	logic                   sat_hit;
	always_comb begin
		rnd = (acc_q + AccW'(32768)) >>> 16;
		sum = rnd + AccW'(res_q);
		sat_hit = 1'b0;
		sat_val = sum[31:0];
		if (sum > AccW'(signed'(32'h7fffffff))) begin
			sat_val = 32'sh7fffffff; sat_hit = 1'b1;
		end else if (sum < -(AccW'(64'sh80000000))) begin
			sat_val = 32'sh80000000; sat_hit = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD && cmd.mode == MODE_RES)
			res_mem[cmd.address[VecAw-1:0]] <= cmd.data_value;
		else if (wb_q && cmd.commit)
			res_mem[wb_addr_q] <= sat_val;
		res_q <= res_mem[cmd.res_addr];
	end

	// Multiply then accumulate, one product per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1 <= 1'b0; mac_s2 <= 1'b0; wb_q <= 1'b0; sat_q <= 1'b0;
		end else begin
			mac_s1 <= cmd.op == OP_MAC;
			mac_s2 <= mac_s1;
			wb_q   <= cmd.op == OP_WB;
			sat_q  <= wb_q && cmd.commit && sat_hit;
		end
	end
	always_ff @(posedge clk) begin
		prod_s2 <= elem_s1 * vec_s1;
		if (cmd.acc_clear) acc_q <= '0;
		else if (mac_s2) acc_q <= acc_q + AccW'(prod_s2);
		if (cmd.op == OP_WB) wb_addr_q <= cmd.res_addr;
	end

	assign stat.ptr_data = ptr_q;
	assign stat.col_data = col_q;
	assign stat.res_sat  = sat_q;
	assign res_rd        = res_q;
endmodule

// File: hw/rtl/bcsr_ctrl.sv
// Controller: handshake, item decode, structure check and block walk sequencer.
module bcsr_ctrl import bcsr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item,
	input  logic [9:0] rows_cfg,
	input  logic      trans_cfg,
	output dp_cmd_t   cmd,
	input  dp_stat_t  stat,
	input  logic signed [31:0] res_rd
);
	localparam logic [3:0] S_IDLE = 4'd0, S_READ = 4'd1, S_CHK_P = 4'd2, S_CHK_PW = 4'd3,
		S_RP0 = 4'd4, S_RP0W = 4'd5, S_RP1 = 4'd6, S_RP1W = 4'd7, S_BCOL = 4'd8,
		S_BCOLW = 4'd9, S_MAC = 4'd10, S_DRAIN = 4'd11, S_WB = 4'd12, S_WB2 = 4'd13,
		S_DONE = 4'd14, S_RESP = 4'd15;

	logic [3:0]       state_q;
	logic             commit_q;   // second pass writes r, first pass checks only
	logic [RowW-1:0]  row_q;
	logic [11:0]      jb_q, jend_q;
	logic [8:0]       colv_q;
	logic [BsW-1:0]   e_q, w_q;
	logic [2:0]       dr_q;
	logic             bad_q, sat_acc_q;
	out_item_t        out_q;
	logic             out_v_q;

	logic [VecAw-1:0] mac_vec, res_idx;
	logic [ElemAw-1:0] base, mac_elem;
	always_comb begin
		base = ElemAw'(jb_q) * ElemAw'(BlockSize * BlockSize);
		if (trans_cfg) begin
			mac_elem = base + ElemAw'(w_q) * ElemAw'(BlockSize) + ElemAw'(e_q);
			mac_vec  = VecAw'(row_q) * VecAw'(BlockSize) + VecAw'(w_q);
			res_idx  = VecAw'(colv_q) * VecAw'(BlockSize) + VecAw'(e_q);
		end else begin
			mac_elem = base + ElemAw'(e_q) * ElemAw'(BlockSize) + ElemAw'(w_q);
			mac_vec  = VecAw'(colv_q) * VecAw'(BlockSize) + VecAw'(w_q);
			res_idx  = VecAw'(row_q) * VecAw'(BlockSize) + VecAw'(e_q);
		end
	end

	// Command generation.
	always_comb begin
		cmd = '0;
		cmd.mode = in_item.mode;
		cmd.address = in_item.address;
		cmd.data_value = in_item.data_value;
		cmd.pointer_value = in_item.pointer_value;
		cmd.column_value = in_item.column_value;
		cmd.ptr_addr = PtrAw'(row_q);
		cmd.col_addr = jb_q[ColAw-1:0];
		cmd.elem_addr = mac_elem;
		cmd.vec_addr = mac_vec;
		cmd.res_addr = res_idx;
		cmd.commit = commit_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.res_addr = in_item.address[VecAw-1:0];
				if (in_valid && in_ready && in_item.mode <= MODE_RES) cmd.op = OP_LOAD;
			end
			S_RP0, S_CHK_P: cmd.op = OP_PTR_RD;
			S_RP1: begin cmd.op = OP_PTR_RD; cmd.ptr_addr = PtrAw'(row_q + 1'b1); end
			S_BCOL: cmd.op = OP_COL_RD;
			S_MAC: begin cmd.op = OP_MAC; cmd.acc_clear = (w_q == '0) && (dr_q == 3'd0); end
			S_WB: cmd.op = OP_WB;
			default: ;
		endcase
		if (state_q == S_MAC && w_q == '0) cmd.acc_clear = 1'b1;
	end

	logic in_range;
	always_comb begin
		unique case (in_item.mode)
			MODE_PTR:  in_range = 32'(in_item.address) < PtrDepth;
			MODE_COL:  in_range = 32'(in_item.address) < MaxBlocks;
			MODE_ELEM: in_range = 32'(in_item.address) < ElemDepth;
			MODE_VEC, MODE_RES, MODE_READ: in_range = 32'(in_item.address) < VecDepth;
			MODE_COMPUTE: in_range = 1'b1;
			default:   in_range = 1'b0;
		endcase
	end

	logic rows_bad;
	assign rows_bad = 32'(rows_cfg) > MaxBlockRows;

	// Result beat request; out_valid is registered from it.
	logic out_set;
	always_comb begin
		unique case (state_q)
			S_IDLE:  out_set = in_valid && in_ready && (!in_range ||
				(in_item.mode == MODE_COMPUTE && rows_bad) ||
				(in_item.mode != MODE_READ && in_item.mode != MODE_COMPUTE));
			S_READ:  out_set = 1'b1;
			S_DONE:  out_set = bad_q || commit_q;
			default: out_set = 1'b0;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE) && !(out_v_q && !out_ready);
	assign out_valid = out_v_q;
	assign out_item  = out_q;

	logic [RowW-1:0] nrows;
	assign nrows = RowW'(rows_cfg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; out_v_q <= 1'b0; commit_q <= 1'b0;
			row_q <= '0; jb_q <= '0; jend_q <= '0; colv_q <= '0; e_q <= '0; w_q <= '0;
			dr_q <= '0; bad_q <= 1'b0; sat_acc_q <= 1'b0; out_q <= '0;
		end else begin
			if (out_set) out_v_q <= 1'b1;
			else if (out_v_q && out_ready) out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					out_q <= '{read_value: '0,
						status: (!in_range || (in_item.mode == MODE_COMPUTE && rows_bad))
							? ST_RANGE : ST_OK};
					if (in_range) begin
						if (in_item.mode == MODE_READ) begin
							state_q <= S_READ;
						end else if (in_item.mode == MODE_COMPUTE) begin
							row_q <= '0; bad_q <= 1'b0; sat_acc_q <= 1'b0; commit_q <= 1'b0;
							if (!rows_bad) state_q <= S_CHK_P;
						end
					end
				end
				S_READ: begin
					out_q.read_value <= res_rd; state_q <= S_IDLE;
				end
				// Pass one: all pointers of rows 0..nrows within range.
				S_CHK_P: state_q <= S_CHK_PW;
				S_CHK_PW: begin
					if (32'(stat.ptr_data) > MaxBlocks) bad_q <= 1'b1;
					if (row_q == nrows) begin row_q <= '0; state_q <= S_RP0; end
					else begin row_q <= row_q + 1'b1; state_q <= S_CHK_P; end
				end
				S_RP0: if (row_q == nrows || bad_q) state_q <= S_DONE;
					else state_q <= S_RP0W;
				S_RP0W: begin jb_q <= stat.ptr_data; state_q <= S_RP1; end
				S_RP1: state_q <= S_RP1W;
				S_RP1W: begin jend_q <= stat.ptr_data; state_q <= S_BCOL; end
				S_BCOL: if (jb_q >= jend_q) begin
						row_q <= row_q + 1'b1; state_q <= S_RP0;
					end else state_q <= S_BCOLW;
				S_BCOLW: begin
					colv_q <= stat.col_data; e_q <= '0; w_q <= '0;
					if (32'(stat.col_data) >= MaxBlockRows) begin
						bad_q <= 1'b1; state_q <= S_DONE;
					end else if (!commit_q) begin
						jb_q <= jb_q + 1'b1; state_q <= S_BCOL;
					end else state_q <= S_MAC;
				end
				S_MAC: if (w_q == BsW'(BlockSize - 1)) begin
						w_q <= '0; dr_q <= '0; state_q <= S_DRAIN;
					end else w_q <= w_q + 1'b1;
				S_DRAIN: if (dr_q == 3'd2) state_q <= S_WB; else dr_q <= dr_q + 1'b1;
				S_WB: state_q <= S_WB2;
				S_WB2: if (e_q == BsW'(BlockSize - 1)) begin
						jb_q <= jb_q + 1'b1; state_q <= S_BCOL;
					end else begin e_q <= e_q + 1'b1; state_q <= S_MAC; end
				S_DONE: begin
					if (bad_q) begin
						out_q.status <= ST_RANGE; state_q <= S_RESP;
					end else if (!commit_q) begin
						commit_q <= 1'b1; row_q <= '0; state_q <= S_RP0;
					end else begin
						out_q.status <= sat_acc_q ? ST_SAT : ST_DONE;
						state_q <= S_RESP;
					end
				end
				S_RESP: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (stat.res_sat) sat_acc_q <= 1'b1;
		end
	end
endmodule

// File: hw/rtl/block_csr_matvec_accumulate_top.sv
// Each item returns one beat; a new item is taken only in idle, while no beat is held by out_ready low.
// Compute: a check pass (all row pointers, then each row's pointer pair and block columns) and a
// commit pass that walks each row and block through the single MAC and writes back r.
// Reset (arst_n low, asynchronous) clears control, sets rows to 1 and clears transpose;
// stores are undefined until written and get no clearing pass.
module block_csr_matvec_accumulate_top import bcsr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item,
	input  logic      cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [9:0] cfg_data
);
	`include "assert_macros.svh"

	logic [9:0] rows_q;
	logic       trans_q;
	dp_cmd_t    cmd;
	dp_stat_t   stat;
	logic signed [31:0] res_rd;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 10'd1; trans_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROWS:  rows_q <= cfg_data;
				CFG_TRANS: trans_q <= cfg_data[0];
				default:   ;
			endcase
		end
	end

	bcsr_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .in_item, .out_valid, .out_ready, .out_item,
		.rows_cfg(rows_q), .trans_cfg(trans_q), .cmd, .stat, .res_rd
	);

	bcsr_datapath u_dp (.clk, .arst_n, .cmd, .stat, .res_rd);

	`ASSERT_IMPL(a_load_idle, clk, arst_n, cmd.op == OP_LOAD, in_valid && in_ready)
	`ASSERT_IMPL(a_wb_commit, clk, arst_n, stat.res_sat, cmd.commit)
	`ASSERT_NEXT(a_read_zero, clk, arst_n,
		in_valid && in_ready && in_item.mode != MODE_READ, out_item.read_value == 32'sd0)
endmodule
